FILE: rtl/tvc_pkg.sv
// ----------------------------------------------------------------------------
// tvc_pkg: shared types and constants
// Register codes, widths, reset values and the stage struct of the trapezoid
// velocity command pipeline.
// ----------------------------------------------------------------------------
package tvc_pkg;

   localparam int IdxWidth = 3;
   localparam int CsrWidth = 15;

   typedef enum logic [IdxWidth-1:0] {
      REG_SPEED_LIMIT      = 3'd0,
      REG_ACCEL_LIMIT      = 3'd1,
      REG_YAW_RATE_LIMIT   = 3'd2,
      REG_YAW_ACCEL_LIMIT  = 3'd3,
      REG_BRAKING_DISTANCE = 3'd4,
      REG_BRAKING_ANGLE    = 3'd5,
      REG_ANGLE_TOLERANCE  = 3'd6,
      REG_STOP_SPEED       = 3'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      PHASE_GOAL   = 2'd0,
      PHASE_BRAKE  = 2'd1,
      PHASE_CRUISE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      OVR_NONE     = 2'd0,
      OVR_ALARM    = 2'd1,
      OVR_DISABLED = 2'd2
   } ovr_type;

   localparam logic [14:0] RstSpeedLimit     = 15'd2458;
   localparam logic [14:0] RstAccelLimit     = 15'd1229;
   localparam logic [14:0] RstYawRateLimit   = 15'd2458;
   localparam logic [14:0] RstYawAccelLimit  = 15'd1229;
   localparam logic [14:0] RstBrakingDist    = 15'd2458;
   localparam logic [14:0] RstBrakingAngle   = 15'd2458;
   localparam logic [11:0] RstAngleTolerance = 12'd41;
   localparam logic [11:0] RstStopSpeed      = 12'd41;

   localparam logic [15:0] DtMax     = 16'd614;
   localparam logic [15:0] DtDefault = 16'd410;

   // Square-root root width: radicand below 2^32, root 16 bits, one bit a stage
   localparam int SqrtBits = 16;

   // Item state carried alongside the square-root stages
   typedef struct packed {
      logic signed [16:0] v;
      logic signed [16:0] w;
      logic               neg;
      logic        [15:0] aw;
      logic        [15:0] up_v;
      logic        [15:0] dn_v;
      logic        [15:0] up_w;
      logic        [15:0] dn_w;
      phase_type          phase;
      logic               v_sqrt;     // linear schedule from root
      logic        [15:0] sv_fixed;   // schedule when not from root
      logic               w_sqrt;
      logic        [15:0] sw_fixed;   // magnitude
      logic               alarm;
      logic               enabled;
      logic        [11:0] stop_speed;
   } item_type;

endpackage

FILE: rtl/tvc_front.sv
// ----------------------------------------------------------------------------
// tvc_front: input decode and ramp step products
// Defaults an over-range dt; forms ramp steps, radicands, schedule modes.
// Two register stages: products, then scaled steps.
// ----------------------------------------------------------------------------
module tvc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [15:0]   distance_left,
   input  logic signed [15:0]   angle_left,
   input  logic signed [15:0]   measured_speed,
   input  logic signed [15:0]   measured_yaw_rate,
   input  logic        [15:0]   elapsed_time,
   input  logic                 alarm,
   input  logic                 enabled,
   input  logic        [14:0]   speed_limit,
   input  logic        [14:0]   accel_limit,
   input  logic        [14:0]   yaw_rate_limit,
   input  logic        [14:0]   yaw_accel_limit,
   input  logic        [14:0]   braking_distance,
   input  logic        [14:0]   braking_angle,
   input  logic        [11:0]   angle_tolerance,
   input  logic        [11:0]   stop_speed,
   output logic                 out_valid,
   output tvc_pkg::item_type    out_item,
   output logic        [31:0]   rad_v,
   output logic        [31:0]   rad_w
);

   // stage A: products
   logic               a_valid_ff;
   tvc_pkg::item_type  a_item_ff;
   logic [30:0]        a_pv_ff, a_pw_ff;   // a*dt
   logic [31:0]        a_rv_ff, a_rw_ff;

   logic [15:0]        dt;
   logic [16:0]        aang;
   logic               d_pos, d_brake, w_zero, w_brake;
   tvc_pkg::item_type  a_item_in;

   always_comb begin
      dt = (elapsed_time > tvc_pkg::DtMax) ? tvc_pkg::DtDefault : elapsed_time;
      aang = angle_left[15] ? (17'd0 - {angle_left[15], angle_left})
                            : {1'b0, angle_left};
      d_pos   = !distance_left[15] && (distance_left != 16'sd0);
      d_brake = d_pos && ({1'b0, distance_left[14:0]} <= {1'b0, braking_distance});
      w_zero  = aang <= {5'd0, angle_tolerance};
      w_brake = !w_zero && (aang <= {2'd0, braking_angle});

      a_item_in = '0;
      a_item_in.v = {measured_speed[15], measured_speed};
      a_item_in.w = {measured_yaw_rate[15], measured_yaw_rate};
      a_item_in.neg = angle_left[15];
      a_item_in.aw = measured_yaw_rate[15] ? 16'(17'd0 - {1'b1, measured_yaw_rate})
                                           : measured_yaw_rate;
      a_item_in.phase = !d_pos ? tvc_pkg::PHASE_GOAL
                      : (d_brake ? tvc_pkg::PHASE_BRAKE : tvc_pkg::PHASE_CRUISE);
      a_item_in.v_sqrt   = d_brake;
      a_item_in.sv_fixed = d_pos ? {1'b0, speed_limit} : 16'd0;
      a_item_in.w_sqrt   = w_brake;
      a_item_in.sw_fixed = w_zero ? 16'd0 : {1'b0, yaw_rate_limit};
      a_item_in.alarm      = alarm;
      a_item_in.enabled    = enabled;
      a_item_in.stop_speed = stop_speed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_item_ff <= a_item_in;
      a_pv_ff <= 31'({16'd0, accel_limit} * {15'd0, dt});
      a_pw_ff <= 31'({16'd0, yaw_accel_limit} * {15'd0, dt});
      // 2*d*a and 2*|ang|*alpha; only used in the braking zone
      a_rv_ff <= {16'd0, distance_left[14:0], 1'b0} * {17'd0, accel_limit};
      a_rw_ff <= {14'd0, aang, 1'b0} * {17'd0, yaw_accel_limit};
   end

   // stage B: steps; 6x/5 by reciprocal multiply
   logic [33:0] six_v, six_w;
   logic [30:0] dq_v, dq_w;
   tvc_pkg::item_type b_item_in;

   function automatic logic [30:0] div5(input logic [33:0] x);
      // floor(x/5) for x < 2^34: multiply by ceil(2^37/5) and correct
      logic [71:0] p;
      logic [34:0] q;
      logic [36:0] back;
      begin
         p = {38'd0, x} * 72'd27487790695;
         q = 35'(p >> 37);
         back = {2'd0, q} * 37'd5;
         if (back > {3'd0, x}) q = q - 35'd1;
         div5 = 31'(q);
      end
   endfunction

   always_comb begin
      six_v = {3'd0, a_pv_ff} * 34'd6;
      six_w = {3'd0, a_pw_ff} * 34'd6;
      dq_v = div5(six_v);
      dq_w = div5(six_w);
      b_item_in = a_item_ff;
      b_item_in.up_v = 16'(a_pv_ff >> 12);
      b_item_in.up_w = 16'(a_pw_ff >> 12);
      b_item_in.dn_v = 16'(dq_v >> 12);
      b_item_in.dn_w = 16'(dq_w >> 12);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= a_valid_ff;
      end
      out_item <= b_item_in;
      rad_v <= a_rv_ff;
      rad_w <= a_rw_ff;
   end

endmodule

FILE: rtl/tvc_sqrt.sv
// ----------------------------------------------------------------------------
// tvc_sqrt: pipelined integer square root
// Restoring square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module tvc_sqrt #(
   parameter int Bits = tvc_pkg::SqrtBits
) (
   input  logic                 clock,
   input  logic [2*Bits-1:0]    radicand,
   output logic [Bits-1:0]      root
);

   logic [Bits+1:0]   rem_ff  [Bits];
   logic [Bits-1:0]   root_ff [Bits];
   logic [2*Bits-1:0] rad_ff  [Bits];

   for (genvar s = 0; s < Bits; s++) begin : g_stage
      logic [Bits+1:0]   rem_prev, trial, rem_sh;
      logic [Bits-1:0]   root_prev;
      logic [2*Bits-1:0] rad_prev;
      if (s == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
         assign rad_prev  = rad_ff[s-1];
      end
      always_comb begin
         rem_sh = {rem_prev[Bits-1:0], rad_prev[2*Bits-1 -: 2]};
         trial  = {root_prev, 2'b01};
      end
      always_ff @(posedge clock) begin
         if (rem_sh >= trial) begin
            rem_ff[s]  <= rem_sh - trial;
            root_ff[s] <= {root_prev[Bits-2:0], 1'b1};
         end else begin
            rem_ff[s]  <= rem_sh;
            root_ff[s] <= {root_prev[Bits-2:0], 1'b0};
         end
         rad_ff[s] <= {rad_prev[2*Bits-3:0], 2'b00};
      end
   end

   assign root = root_ff[Bits-1];

endmodule

FILE: rtl/tvc_ramp.sv
// ----------------------------------------------------------------------------
// tvc_ramp: schedule select, ramp and override
// Two stages: signed schedule and ramp candidates, then choice and saturation.
// ----------------------------------------------------------------------------
module tvc_ramp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  tvc_pkg::item_type    in_item,
   input  logic        [15:0]   root_v,
   input  logic        [15:0]   root_w,
   output logic                 out_valid,
   output logic signed [15:0]   speed_command,
   output logic signed [15:0]   yaw_rate_command,
   output logic        [1:0]    linear_phase,
   output logic        [1:0]    stop_override
);

   // stage C
   logic               c_valid_ff;
   logic signed [18:0] c_cv_ff, c_cw_ff;
   logic [1:0]         c_phase_ff;
   logic               c_alarm_ff, c_en_ff;
   logic signed [18:0] c_av_ff, c_aw_ff;

   logic signed [18:0] v, w, sv, sw, msw, aw, upv, dnv, upw, dnw, t, m, cv, cw, av, awc;

   always_comb begin
      t   = '0;
      m   = '0;
      v   = 19'(in_item.v);
      w   = 19'(in_item.w);
      aw  = {3'd0, in_item.aw};
      upv = {3'd0, in_item.up_v};
      dnv = {3'd0, in_item.dn_v};
      upw = {3'd0, in_item.up_w};
      dnw = {3'd0, in_item.dn_w};
      sv  = in_item.v_sqrt ? {4'd0, root_v[15:1]} : {3'd0, in_item.sv_fixed};
      msw = in_item.w_sqrt ? {3'd0, root_w} : {3'd0, in_item.sw_fixed};
      sw  = in_item.neg ? -msw : msw;

      if (v < sv) begin
         t = v + upv;
         cv = (t < sv) ? t : sv;
      end else if (v > sv) begin
         t = v - dnv;
         cv = (t > sv) ? t : sv;
      end else begin
         cv = sv;
      end

      if (aw < msw) begin
         t = in_item.neg ? w - upw : w + upw;
         m = t[18] ? -t : t;
         cw = (m < msw) ? t : sw;
      end else if (aw > msw) begin
         m = aw - dnw;
         cw = (m > msw) ? (in_item.neg ? -m : m) : sw;
      end else begin
         cw = sw;
      end

      // signed compare: a negative speed is below the stop threshold
      av  = (v >= signed'({7'd0, in_item.stop_speed})) ? v - upv : '0;
      m   = aw - upw;
      awc = (aw >= signed'({7'd0, in_item.stop_speed})) ? (in_item.neg ? -m : m) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= in_valid;
      end
      c_cv_ff    <= cv;
      c_cw_ff    <= cw;
      c_av_ff    <= av;
      c_aw_ff    <= awc;
      c_phase_ff <= in_item.phase;
      c_alarm_ff <= in_item.alarm;
      c_en_ff    <= in_item.enabled;
   end

   function automatic logic signed [15:0] sat16(input logic signed [18:0] x);
      begin
         if (x > 19'sd32767) sat16 = 16'sh7fff;
         else if (x < -19'sd32768) sat16 = 16'sh8000;
         else sat16 = x[15:0];
      end
   endfunction

   logic signed [18:0] fv, fw;
   logic [1:0]         ovr;

   always_comb begin
      fv = c_cv_ff;
      fw = c_cw_ff;
      ovr = tvc_pkg::OVR_NONE;
      if (c_alarm_ff) begin
         fv = c_av_ff;
         fw = c_aw_ff;
         ovr = tvc_pkg::OVR_ALARM;
      end
      if (!c_en_ff) begin
         fv = '0;
         fw = '0;
         ovr = tvc_pkg::OVR_DISABLED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= c_valid_ff;
      end
      speed_command    <= sat16(fv);
      yaw_rate_command <= sat16(fw);
      linear_phase     <= c_phase_ff;
      stop_override    <= ovr;
   end

endmodule

FILE: rtl/trapezoid_velocity_command_unit.sv
// ----------------------------------------------------------------------------
// trapezoid_velocity_command_unit: trapezoidal speed and yaw-rate commands
// Braking-curve schedules via pipelined square root, ramp limiting, stops.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  req_      start / busy          distance, angle, speeds, time, flags
//  rsp_      rsp_valid (strobe)    speed, yaw rate, phase, override
//  csr_      csr_valid / csr_ready index, data
//
// One request per cycle while busy is low; results pass through the front,
// the one-bit-per-stage square root and the ramp stages in order.
// busy is low whenever reset is low; the receiver cannot stall.
// Synchronous reset clears valid bits and reloads register defaults.
// ----------------------------------------------------------------------------
module trapezoid_velocity_command_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [15:0]   req_distance_left,
   input  logic signed [15:0]   req_angle_left,
   input  logic signed [15:0]   req_measured_speed,
   input  logic signed [15:0]   req_measured_yaw_rate,
   input  logic        [15:0]   req_elapsed_time,
   input  logic                 req_obstacle_alarm,
   input  logic                 req_soft_stop,
   input  logic                 req_motors_enabled,
   output logic                 rsp_valid,
   output logic signed [15:0]   rsp_speed_command,
   output logic signed [15:0]   rsp_yaw_rate_command,
   output logic        [1:0]    rsp_linear_phase,
   output logic        [1:0]    rsp_stop_override,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic        [tvc_pkg::IdxWidth-1:0] csr_index,
   input  logic        [tvc_pkg::CsrWidth-1:0] csr_data
);

   logic [14:0] speed_limit_ff, accel_limit_ff, yaw_rate_limit_ff, yaw_accel_limit_ff;
   logic [14:0] braking_distance_ff, braking_angle_ff;
   logic [11:0] angle_tolerance_ff, stop_speed_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff      <= tvc_pkg::RstSpeedLimit;
         accel_limit_ff      <= tvc_pkg::RstAccelLimit;
         yaw_rate_limit_ff   <= tvc_pkg::RstYawRateLimit;
         yaw_accel_limit_ff  <= tvc_pkg::RstYawAccelLimit;
         braking_distance_ff <= tvc_pkg::RstBrakingDist;
         braking_angle_ff    <= tvc_pkg::RstBrakingAngle;
         angle_tolerance_ff  <= tvc_pkg::RstAngleTolerance;
         stop_speed_ff       <= tvc_pkg::RstStopSpeed;
      end else if (csr_valid) begin
         unique case (tvc_pkg::reg_idx_type'(csr_index))
            tvc_pkg::REG_SPEED_LIMIT:      speed_limit_ff      <= csr_data;
            tvc_pkg::REG_ACCEL_LIMIT:      accel_limit_ff      <= csr_data;
            tvc_pkg::REG_YAW_RATE_LIMIT:   yaw_rate_limit_ff   <= csr_data;
            tvc_pkg::REG_YAW_ACCEL_LIMIT:  yaw_accel_limit_ff  <= csr_data;
            tvc_pkg::REG_BRAKING_DISTANCE: braking_distance_ff <= csr_data;
            tvc_pkg::REG_BRAKING_ANGLE:    braking_angle_ff    <= csr_data;
            tvc_pkg::REG_ANGLE_TOLERANCE:  angle_tolerance_ff  <= csr_data[11:0];
            tvc_pkg::REG_STOP_SPEED:       stop_speed_ff       <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   logic              f_valid;
   tvc_pkg::item_type f_item;
   logic [31:0]       rad_v, rad_w;

   tvc_front u_front (
      .clock, .reset,
      .in_valid          (start && !busy),
      .distance_left     (req_distance_left),
      .angle_left        (req_angle_left),
      .measured_speed    (req_measured_speed),
      .measured_yaw_rate (req_measured_yaw_rate),
      .elapsed_time      (req_elapsed_time),
      .alarm             (req_obstacle_alarm || req_soft_stop),
      .enabled           (req_motors_enabled),
      .speed_limit       (speed_limit_ff),
      .accel_limit       (accel_limit_ff),
      .yaw_rate_limit    (yaw_rate_limit_ff),
      .yaw_accel_limit   (yaw_accel_limit_ff),
      .braking_distance  (braking_distance_ff),
      .braking_angle     (braking_angle_ff),
      .angle_tolerance   (angle_tolerance_ff),
      .stop_speed        (stop_speed_ff),
      .out_valid         (f_valid),
      .out_item          (f_item),
      .rad_v, .rad_w
   );

   logic [15:0] root_v, root_w;

   tvc_sqrt #(.Bits(tvc_pkg::SqrtBits)) u_sqrt_v (.clock, .radicand(rad_v), .root(root_v));
   tvc_sqrt #(.Bits(tvc_pkg::SqrtBits)) u_sqrt_w (.clock, .radicand(rad_w), .root(root_w));

   // delay line carrying item state alongside the roots
   logic              d_valid_ff [tvc_pkg::SqrtBits];
   tvc_pkg::item_type d_item_ff  [tvc_pkg::SqrtBits];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tvc_pkg::SqrtBits; i++) d_valid_ff[i] <= 1'b0;
      end else begin
         d_valid_ff[0] <= f_valid;
         for (int i = 1; i < tvc_pkg::SqrtBits; i++) d_valid_ff[i] <= d_valid_ff[i-1];
      end
      d_item_ff[0] <= f_item;
      for (int i = 1; i < tvc_pkg::SqrtBits; i++) d_item_ff[i] <= d_item_ff[i-1];
   end

   tvc_ramp u_ramp (
      .clock, .reset,
      .in_valid         (d_valid_ff[tvc_pkg::SqrtBits-1]),
      .in_item          (d_item_ff[tvc_pkg::SqrtBits-1]),
      .root_v, .root_w,
      .out_valid        (rsp_valid),
      .speed_command    (rsp_speed_command),
      .yaw_rate_command (rsp_yaw_rate_command),
      .linear_phase     (rsp_linear_phase),
      .stop_override    (rsp_stop_override)
   );

endmodule

FILE: rtl/tvc_checker.sv
// ----------------------------------------------------------------------------
// tvc_checker: port-level assertions
// Checks result codes, override consistency, reset and busy on the top ports.
// ----------------------------------------------------------------------------
module tvc_checker (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input logic signed [15:0] rsp_speed_command,
   input logic signed [15:0] rsp_yaw_rate_command,
   input logic        [1:0] rsp_linear_phase,
   input logic        [1:0] rsp_stop_override
);

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_override == tvc_pkg::OVR_DISABLED |->
         rsp_speed_command == 16'sd0 && rsp_yaw_rate_command == 16'sd0)
      else $error("disabled motors gave non-zero command");

   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_linear_phase != 2'd3 && rsp_stop_override != 2'd3)
      else $error("undefined result code");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result straight after reset");

   a_busy_only_reset: assert property (@(posedge clock)
      !reset |-> !busy)
      else $error("busy outside reset");

endmodule

bind trapezoid_velocity_command_unit tvc_checker u_checker (
   .clock, .reset, .busy, .rsp_valid, .rsp_speed_command, .rsp_yaw_rate_command,
   .rsp_linear_phase, .rsp_stop_override
);
